@@ sv/abbg_pkg.sv @@
`timescale 1ns / 1ps
// Shared types and constants of the arcade board bus glue.
package abbg_pkg;

   localparam int unsigned COLOUR_ENTRIES = 32;
   localparam int unsigned SPRITE_ENTRIES = 16;
   localparam int unsigned COLOUR_IDX_W   = $clog2(COLOUR_ENTRIES);
   localparam int unsigned SPRITE_IDX_W   = $clog2(SPRITE_ENTRIES);

   localparam logic [7:0]  WATCHDOG_LIMIT = 8'd180;

   localparam logic [12:0] ADDR_MASK_COLOUR = 13'h1c00;
   localparam logic [12:0] ADDR_BASE_COLOUR = 13'h1000;
   localparam logic [12:0] ADDR_MASK_SPRITE = 13'h1ff0;
   localparam logic [12:0] ADDR_BASE_SPRITE = 13'h1560;
   localparam logic [12:0] ADDR_FLIP        = 13'h1503;
   localparam logic [12:0] ADDR_COIN        = 13'h1507;
   localparam logic [12:0] ADDR_WATCHDOG    = 13'h15c0;
   localparam logic [12:0] ADDR_BANK        = 13'h15c7;
   localparam logic [12:0] ADDR_IN0         = 13'h1500;
   localparam logic [12:0] ADDR_IN1         = 13'h1540;
   localparam logic [12:0] ADDR_DIP         = 13'h1580;

   localparam logic [8:0]  PORT_DATA  = 9'h101;
   localparam logic [8:0]  PORT_SENSE = 9'h102;
   localparam logic [8:0]  PORT_PROT  = 9'h001;

   localparam logic [14:0] PROT_PC_A = 15'h0030;
   localparam logic [14:0] PROT_PC_B = 15'h0034;
   localparam logic [14:0] PROT_PC_C = 15'h0291;
   localparam logic [14:0] PROT_PC_D = 15'h0466;

   typedef enum logic [2:0] {
      OP_MEM_WRITE  = 3'd0,
      OP_MEM_READ   = 3'd1,
      OP_PORT_WRITE = 3'd2,
      OP_PORT_READ  = 3'd3,
      OP_FRAME_TICK = 3'd4,
      OP_FETCH      = 3'd5
   } op_type;

   typedef enum logic [1:0] {
      FETCH_NONE   = 2'd0,
      FETCH_COLOUR = 2'd1,
      FETCH_SPRITE = 2'd2
   } fetch_type;

   typedef struct packed {
      logic                    colour_we;
      logic                    sprite_we;
      logic [COLOUR_IDX_W-1:0] wr_idx;
      logic [7:0]              wr_data;
      logic                    rd_en;
      fetch_type               rd_sel;
      logic [COLOUR_IDX_W-1:0] rd_idx;
   } store_ctl_type;

endpackage

@@ sv/abbg_req_if.sv @@
`timescale 1ns / 1ps
// Request and response channel interfaces of the arcade board bus glue.
interface abbg_req_if;
   logic        valid;
   logic        ready;
   logic [2:0]  operation;
   logic [15:0] address;
   logic [7:0]  data;
   logic [14:0] cpu_pc;
   logic        in_vblank;
   logic [7:0]  joy_one;
   logic [7:0]  joy_two;

   modport source (output valid, operation, address, data, cpu_pc, in_vblank,
                   joy_one, joy_two, input ready);
   modport sink (input valid, operation, address, data, cpu_pc, in_vblank,
                 joy_one, joy_two, output ready);
endinterface

interface abbg_rsp_if;
   logic       valid;
   logic       ready;
   logic [7:0] read_data;
   logic       rom_bank;
   logic       flip_screen;
   logic       sound_strobe;
   logic [7:0] sound_byte;
   logic       cpu_reset_request;

   modport source (output valid, read_data, rom_bank, flip_screen, sound_strobe,
                   sound_byte, cpu_reset_request, input ready);
   modport sink (input valid, read_data, rom_bank, flip_screen, sound_strobe,
                 sound_byte, cpu_reset_request, output ready);
endinterface

@@ sv/abbg_store.sv @@
`timescale 1ns / 1ps
// Colour and sprite position stores with registered read port.
module abbg_store (
   input  logic                   clock,
   input  logic                   reset,
   input  abbg_pkg::store_ctl_type ctl,
   output logic [7:0]             rd_data
);

   logic [7:0] colour_mem [abbg_pkg::COLOUR_ENTRIES];
   logic [7:0] sprite_mem [abbg_pkg::SPRITE_ENTRIES];
   logic [abbg_pkg::COLOUR_ENTRIES-1:0] colour_vld_ff;
   logic [abbg_pkg::SPRITE_ENTRIES-1:0] sprite_vld_ff;
   logic [abbg_pkg::SPRITE_IDX_W-1:0]   spr_wr_idx;
   logic [abbg_pkg::SPRITE_IDX_W-1:0]   spr_rd_idx;
   logic [7:0]                          rd_data_ff;

   assign spr_wr_idx = ctl.wr_idx[abbg_pkg::SPRITE_IDX_W-1:0];
   assign spr_rd_idx = ctl.rd_idx[abbg_pkg::SPRITE_IDX_W-1:0];
   assign rd_data    = rd_data_ff;

   always_ff @(posedge clock) begin
      if (ctl.colour_we) begin
         colour_mem[ctl.wr_idx] <= ctl.wr_data;
      end
      if (ctl.sprite_we) begin
         sprite_mem[spr_wr_idx] <= ctl.wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         colour_vld_ff <= '0;
         sprite_vld_ff <= '0;
      end else begin
         if (ctl.colour_we) begin
            colour_vld_ff[ctl.wr_idx] <= 1'b1;
         end
         if (ctl.sprite_we) begin
            sprite_vld_ff[spr_wr_idx] <= 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (ctl.rd_en) begin
         case (ctl.rd_sel)
            abbg_pkg::FETCH_COLOUR: begin
               rd_data_ff <= colour_vld_ff[ctl.rd_idx] ? colour_mem[ctl.rd_idx] : 8'h00;
            end
            abbg_pkg::FETCH_SPRITE: begin
               rd_data_ff <= sprite_vld_ff[spr_rd_idx] ? sprite_mem[spr_rd_idx] : 8'h00;
            end
            default: begin
               rd_data_ff <= 8'h00;
            end
         endcase
      end
   end

endmodule

@@ sv/arcade_board_bus_glue.sv @@
`timescale 1ns / 1ps
// Top level of the arcade board bus glue.
// Takes one bus beat per cycle on req_chan while rsp_chan does not stall
// (memory write or read, port write or read, frame tick, display fetch) and
// returns exactly one response beat on rsp_chan for each. Every response is
// registered and appears in the cycle after its request beat, read data
// coming from the registered store read port or the output register.
// The response carries read data, the ROM bank and flip bit after the beat, the
// sound strobe and byte, and the watchdog reset request. The DIP byte is loaded
// through csr_wr_en / csr_wr_data; the user keeps the bus idle, the block does not check.
// Reset clears flip, bank, watchdog and DIP byte, sets both input latches to
// all ones and marks every store entry as zero; no clearing pass is needed.
// When rsp_chan stalls, the pending response holds and req_chan takes one
// more beat only as the response drains, so nothing is lost or repeated.
module arcade_board_bus_glue (
   input  logic       clock,
   input  logic       reset,
   abbg_req_if.sink   req_chan,
   abbg_rsp_if.source rsp_chan,
   input  logic       csr_wr_en,
   input  logic [7:0] csr_wr_data
);

   logic        accept;
   logic [12:0] maddr;
   logic [8:0]  paddr;
   logic        col_hit;
   logic        spr_hit;
   logic        prot_pc;
   abbg_pkg::op_type       op;
   abbg_pkg::store_ctl_type store_ctl;
   logic [7:0]  store_q;

   logic        flip_ff, flip_in;
   logic        bank_ff, bank_in;
   logic [7:0]  wdog_ff, wdog_in;
   logic [7:0]  latch0_ff, latch0_in;
   logic [7:0]  latch1_ff, latch1_in;
   logic [7:0]  dip_ff;

   logic        rsp_valid_ff;
   logic        fetch_ff, fetch_in;
   logic [7:0]  rd_ff, rd_in;
   logic        strobe_ff, strobe_in;
   logic [7:0]  sbyte_ff, sbyte_in;
   logic        rst_ff, rst_in;
   logic        out_bank_ff;
   logic        out_flip_ff;

   assign req_chan.ready = !rsp_valid_ff || rsp_chan.ready;
   assign accept         = req_chan.valid && req_chan.ready;

   assign op      = abbg_pkg::op_type'(req_chan.operation);
   assign maddr   = req_chan.address[12:0];
   assign paddr   = req_chan.address[8:0];
   assign col_hit = (maddr & abbg_pkg::ADDR_MASK_COLOUR) == abbg_pkg::ADDR_BASE_COLOUR;
   assign spr_hit = (maddr & abbg_pkg::ADDR_MASK_SPRITE) == abbg_pkg::ADDR_BASE_SPRITE;
   assign prot_pc = (req_chan.cpu_pc == abbg_pkg::PROT_PC_A) ||
                    (req_chan.cpu_pc == abbg_pkg::PROT_PC_B) ||
                    (req_chan.cpu_pc == abbg_pkg::PROT_PC_C) ||
                    (req_chan.cpu_pc == abbg_pkg::PROT_PC_D);

   always_comb begin
      flip_in   = flip_ff;
      bank_in   = bank_ff;
      wdog_in   = wdog_ff;
      latch0_in = latch0_ff;
      latch1_in = latch1_ff;
      rd_in     = 8'h00;
      strobe_in = 1'b0;
      sbyte_in  = 8'h00;
      rst_in    = 1'b0;
      fetch_in  = 1'b0;
      store_ctl.colour_we = 1'b0;
      store_ctl.sprite_we = 1'b0;
      store_ctl.wr_idx    = maddr[abbg_pkg::COLOUR_IDX_W-1:0];
      store_ctl.wr_data   = req_chan.data;
      store_ctl.rd_en     = accept;
      store_ctl.rd_sel    = abbg_pkg::FETCH_NONE;
      store_ctl.rd_idx    = req_chan.address[abbg_pkg::COLOUR_IDX_W-1:0];
      case (op)
         abbg_pkg::OP_MEM_WRITE: begin
            if (maddr == abbg_pkg::ADDR_FLIP) begin
               flip_in = req_chan.data[0];
            end else if (maddr == abbg_pkg::ADDR_COIN) begin
               flip_in = flip_ff;
            end else if (maddr == abbg_pkg::ADDR_WATCHDOG) begin
               wdog_in = 8'h00;
            end else if (maddr == abbg_pkg::ADDR_BANK) begin
               bank_in = req_chan.data[0];
            end else if (col_hit) begin
               store_ctl.colour_we = accept;
            end else if (spr_hit) begin
               store_ctl.sprite_we = accept;
            end
         end
         abbg_pkg::OP_MEM_READ: begin
            if (maddr == abbg_pkg::ADDR_IN0) begin
               rd_in = latch0_ff;
            end else if (maddr == abbg_pkg::ADDR_IN1) begin
               rd_in = latch1_ff;
            end else if (maddr == abbg_pkg::ADDR_DIP) begin
               rd_in = dip_ff;
            end
         end
         abbg_pkg::OP_PORT_WRITE: begin
            if (paddr == abbg_pkg::PORT_DATA) begin
               strobe_in = 1'b1;
               sbyte_in  = req_chan.data;
            end
         end
         abbg_pkg::OP_PORT_READ: begin
            if (paddr == abbg_pkg::PORT_SENSE) begin
               rd_in = req_chan.in_vblank ? 8'h00 : 8'h80;
            end else if (paddr == abbg_pkg::PORT_PROT) begin
               rd_in = {7'd0, prot_pc};
            end
         end
         abbg_pkg::OP_FRAME_TICK: begin
            if (wdog_ff >= abbg_pkg::WATCHDOG_LIMIT) begin
               rst_in  = 1'b1;
               bank_in = 1'b0;
               wdog_in = 8'h01;
            end else begin
               wdog_in = wdog_ff + 8'h01;
            end
            latch0_in = ~req_chan.joy_one;
            latch1_in = ~req_chan.joy_two;
         end
         abbg_pkg::OP_FETCH: begin
            fetch_in = 1'b1;
            if (req_chan.address < 16'(abbg_pkg::COLOUR_ENTRIES)) begin
               store_ctl.rd_sel = abbg_pkg::FETCH_COLOUR;
            end else if (req_chan.address <
                         16'(abbg_pkg::COLOUR_ENTRIES + abbg_pkg::SPRITE_ENTRIES)) begin
               store_ctl.rd_sel = abbg_pkg::FETCH_SPRITE;
            end
         end
         default: begin
            rd_in = 8'h00;
         end
      endcase
   end

   abbg_store u_store (
      .clock   (clock),
      .reset   (reset),
      .ctl     (store_ctl),
      .rd_data (store_q)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         flip_ff      <= 1'b0;
         bank_ff      <= 1'b0;
         wdog_ff      <= 8'h00;
         latch0_ff    <= 8'hff;
         latch1_ff    <= 8'hff;
         dip_ff       <= 8'h00;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (csr_wr_en) begin
            dip_ff <= csr_wr_data;
         end
         if (accept) begin
            flip_ff   <= flip_in;
            bank_ff   <= bank_in;
            wdog_ff   <= wdog_in;
            latch0_ff <= latch0_in;
            latch1_ff <= latch1_in;
         end
         if (accept) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_chan.ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         fetch_ff    <= fetch_in;
         rd_ff       <= rd_in;
         strobe_ff   <= strobe_in;
         sbyte_ff    <= sbyte_in;
         rst_ff      <= rst_in;
         out_bank_ff <= bank_in;
         out_flip_ff <= flip_in;
      end
   end

   assign rsp_chan.valid             = rsp_valid_ff;
   assign rsp_chan.read_data         = fetch_ff ? store_q : rd_ff;
   assign rsp_chan.rom_bank          = out_bank_ff;
   assign rsp_chan.flip_screen       = out_flip_ff;
   assign rsp_chan.sound_strobe      = strobe_ff;
   assign rsp_chan.sound_byte        = sbyte_ff;
   assign rsp_chan.cpu_reset_request = rst_ff;

endmodule
